### rtl/psched_pkg.sv
`default_nettype none
package psched_pkg;

    localparam int LEVELS = 4;
    localparam int SLOTS  = 8;
    localparam int TOTAL  = LEVELS * SLOTS;

    localparam int IDX_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int LV_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVC_W  = $clog2(LEVELS + 1);
    localparam int SL_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);

    localparam logic [1:0] ADDR_TICK_STEP = 2'd0;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_DELAY   = 3'd2;
    localparam logic [2:0] CMD_SUSPEND = 3'd3;
    localparam logic [2:0] CMD_RESUME  = 3'd4;

    localparam logic [1:0] MODE_WAIT    = 2'd0;
    localparam logic [1:0] MODE_DELAYED = 2'd1;
    localparam logic [1:0] MODE_SUSP    = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOTASK = 2'd2;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ANSWER  = 1'b1;

    // Classified command handed from the front end to the execution engine
    typedef struct packed {
        logic [2:0]      cmd;
        logic [4:0]      task_id;
        logic            tid_ok;
        logic [LV_W-1:0] lv;
        logic [SL_W-1:0] slot;
        logic [1:0]      prio;
        logic [31:0]     period;
        logic [31:0]     first_delay;
        logic [15:0]     delay_ticks;
    } item_t;

    function automatic logic [IDX_W-1:0] task_index(input logic [LV_W-1:0] lv,
                                                    input logic [SL_W-1:0] sl);
        int v;
        v = int'(lv) * SLOTS + int'(sl);
        return IDX_W'(v);
    endfunction

endpackage
`default_nettype wire

### rtl/psched_div.sv
`default_nettype none
// Restoring remainder unit, one quotient bit per cycle.
module psched_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [31:0]      rem
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] rem_step;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[31]};
        diff     = trial - {1'b0, dsr_reg};
        rem_step = (trial >= {1'b0, dsr_reg}) ? diff[31:0] : trial[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

### rtl/psched_front.sv
`default_nettype none
// Accept commands, decode the target id, drop unknown codes, queue two deep.
module psched_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          command,
    input  wire logic [4:0]          task_id,
    input  wire logic [1:0]          priority_req,
    input  wire logic [31:0]         period,
    input  wire logic [31:0]         first_delay,
    input  wire logic [15:0]         delay_ticks,
    output logic                     q_valid,
    input  wire logic                q_pop,
    output psched_pkg::item_t        q_item
);

    psched_pkg::item_t q_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    psched_pkg::item_t cls;
    logic              known;
    logic              push;
    logic [4:0]        tid_lv;

    always_comb
    begin
        tid_lv          = task_id / 5'(psched_pkg::SLOTS);
        cls.cmd         = command;
        cls.task_id     = task_id;
        cls.tid_ok      = (32'(tid_lv) < 32'(psched_pkg::LEVELS));
        cls.lv          = psched_pkg::LV_W'(tid_lv);
        cls.slot        = psched_pkg::SL_W'(task_id % 5'(psched_pkg::SLOTS));
        cls.prio        = priority_req;
        cls.period      = period;
        cls.first_delay = first_delay;
        cls.delay_ticks = delay_ticks;
        unique case (command) inside
            psched_pkg::CMD_TICK, psched_pkg::CMD_CREATE, psched_pkg::CMD_DELAY,
            psched_pkg::CMD_SUSPEND, psched_pkg::CMD_RESUME: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && known;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule
`default_nettype wire

### rtl/psched_back.sv
`default_nettype none
// Execute queued commands: table updates, tick walk, time advance, result register.
module psched_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire psched_pkg::item_t  q_item,
    input  wire logic [15:0]        step,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [4:0]              out_task,
    output logic                    kind,
    output logic [1:0]              status,
    output logic                    last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WALK  = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_REL   = 4'd4;
    localparam logic [3:0] S_FLUSH = 4'd5;
    localparam logic [3:0] S_ADV   = 4'd6;
    localparam logic [3:0] S_ADVW  = 4'd7;
    localparam logic [3:0] S_ANS   = 4'd8;

    localparam int IW = psched_pkg::IDX_W;

    logic [3:0]                      state_reg, state_next;
    logic [psched_pkg::LVC_W-1:0]    lv_reg, lv_next;
    logic [psched_pkg::SL_W-1:0]     sl_reg, sl_next;
    logic [psched_pkg::FILL_W-1:0]   fill_reg [psched_pkg::LEVELS];
    logic [1:0]                      mode_reg [psched_pkg::TOTAL];
    logic [31:0]                     rt_reg, rt_next;
    logic [31:0]                     sum_reg, sum_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [IW-1:0]                   pend_idx_reg, pend_idx_next;
    logic [4:0]                      ans_task_reg, ans_task_next;
    logic [1:0]                      ans_status_reg, ans_status_next;
    logic                            ovalid_reg;
    logic [4:0]                      otask_reg;
    logic                            okind_reg;
    logic [1:0]                      ostatus_reg;
    logic                            olast_reg;

    logic [31:0] per_mem  [psched_pkg::TOTAL];
    logic [31:0] off_mem  [psched_pkg::TOTAL];
    logic [15:0] hold_mem [psched_pkg::TOTAL];
    logic [31:0] per_rd;
    logic [31:0] off_rd;
    logic [15:0] hold_rd;

    logic                           out_free;
    logic                           out_load;
    logic [4:0]                     load_task;
    logic                           load_kind;
    logic [1:0]                     load_status;
    logic                           load_last;
    logic [IW-1:0]                  cur_idx;
    logic [psched_pkg::LV_W-1:0]    cur_lv;
    logic                           at_end;
    logic                           adv;
    logic                           tab_we;
    logic [IW-1:0]                  tab_widx;
    logic                           hold_we;
    logic [IW-1:0]                  hold_widx;
    logic [15:0]                    hold_wdata;
    logic                           mode_we;
    logic [IW-1:0]                  mode_widx;
    logic [1:0]                     mode_wdata;
    logic                           fill_we;
    logic [psched_pkg::LV_W-1:0]    fill_widx;
    logic                           div_start;
    logic [31:0]                    div_dvd;
    logic [31:0]                    div_dsr;
    logic                           div_busy;
    logic                           div_done;
    logic [31:0]                    div_rem;
    logic [psched_pkg::LV_W-1:0]    cr_lv;
    logic [psched_pkg::SL_W-1:0]    cr_sl;
    logic                           cr_full;
    logic [IW-1:0]                  cr_idx;
    logic [IW-1:0]                  tg_idx;
    logic                           tg_ok;
    logic [15:0]                    hold_dec;

    psched_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign out_free = !ovalid_reg || out_ready;
    assign cur_lv   = psched_pkg::LV_W'(lv_reg);
    assign cur_idx  = psched_pkg::task_index(cur_lv, sl_reg);
    assign at_end   = (32'(sl_reg) == psched_pkg::SLOTS - 1);
    assign hold_dec = hold_rd - 16'd1;

    always_comb
    begin
        cr_lv   = psched_pkg::LV_W'(q_item.prio);
        cr_full = (32'(q_item.prio) >= 32'(psched_pkg::LEVELS))
                  || (32'(fill_reg[cr_lv]) >= 32'(psched_pkg::SLOTS));
        cr_sl   = psched_pkg::SL_W'(fill_reg[cr_lv]);
        cr_idx  = psched_pkg::task_index(cr_lv, cr_sl);
        tg_idx  = psched_pkg::task_index(q_item.lv, q_item.slot);
        tg_ok   = q_item.tid_ok
                  && (psched_pkg::FILL_W'(q_item.slot) < fill_reg[q_item.lv]);
    end

    always_comb
    begin
        state_next      = state_reg;
        lv_next         = lv_reg;
        sl_next         = sl_reg;
        rt_next         = rt_reg;
        sum_next        = sum_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        ans_task_next   = ans_task_reg;
        ans_status_next = ans_status_reg;
        q_pop           = 1'b0;
        out_load        = 1'b0;
        load_task       = ans_task_reg;
        load_kind       = psched_pkg::KIND_ANSWER;
        load_status     = ans_status_reg;
        load_last       = 1'b1;
        adv             = 1'b0;
        tab_we          = 1'b0;
        tab_widx        = cr_idx;
        hold_we         = 1'b0;
        hold_widx       = cur_idx;
        hold_wdata      = hold_dec;
        mode_we         = 1'b0;
        mode_widx       = cur_idx;
        mode_wdata      = psched_pkg::MODE_WAIT;
        fill_we         = 1'b0;
        fill_widx       = cr_lv;
        div_start       = 1'b0;
        div_dvd         = rt_reg - off_rd;
        div_dsr         = per_rd;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.cmd)
                        psched_pkg::CMD_TICK:
                        begin
                            lv_next    = '0;
                            sl_next    = '0;
                            state_next = S_WALK;
                        end
                        psched_pkg::CMD_CREATE:
                        begin
                            state_next = S_ANS;
                            if (cr_full)
                            begin
                                ans_task_next   = '0;
                                ans_status_next = psched_pkg::ST_FULL;
                            end
                            else
                            begin
                                tab_we          = 1'b1;
                                mode_we         = 1'b1;
                                mode_widx       = cr_idx;
                                fill_we         = 1'b1;
                                ans_task_next   = 5'(cr_idx);
                                ans_status_next = psched_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            state_next    = S_ANS;
                            ans_task_next = q_item.task_id;
                            if (!tg_ok)
                                ans_status_next = psched_pkg::ST_NOTASK;
                            else
                            begin
                                ans_status_next = psched_pkg::ST_OK;
                                mode_we         = 1'b1;
                                mode_widx       = tg_idx;
                                if (q_item.cmd == psched_pkg::CMD_DELAY)
                                begin
                                    mode_wdata = psched_pkg::MODE_DELAYED;
                                    hold_we    = 1'b1;
                                    hold_widx  = tg_idx;
                                    hold_wdata = (q_item.delay_ticks == 16'd0)
                                                 ? 16'd1 : q_item.delay_ticks;
                                end
                                else if (q_item.cmd == psched_pkg::CMD_SUSPEND)
                                    mode_wdata = psched_pkg::MODE_SUSP;
                                else
                                    mode_wdata = psched_pkg::MODE_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (32'(lv_reg) == psched_pkg::LEVELS)
                    state_next = pend_valid_reg ? S_FLUSH : S_ADV;
                else if (psched_pkg::FILL_W'(sl_reg) < fill_reg[cur_lv])
                    state_next = S_EVAL;
                else
                begin
                    lv_next = lv_reg + 1'b1;
                    sl_next = '0;
                end
            end
            S_EVAL:
            begin
                unique case (mode_reg[cur_idx])
                    psched_pkg::MODE_DELAYED:
                    begin
                        hold_we = 1'b1;
                        if (hold_dec == 16'd0)
                        begin
                            mode_we    = 1'b1;
                            state_next = S_REL;
                        end
                        else
                            adv = 1'b1;
                    end
                    psched_pkg::MODE_WAIT:
                    begin
                        if (rt_reg < off_rd)
                            adv = 1'b1;
                        else if (per_rd == 32'd0)
                        begin
                            if (rt_reg == off_rd)
                                state_next = S_REL;
                            else
                                adv = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: adv = 1'b1;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == 32'd0)
                        state_next = S_REL;
                    else
                        adv = 1'b1;
                end
            end
            S_REL:
            begin
                if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = cur_idx;
                    adv             = 1'b1;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    load_task     = 5'(pend_idx_reg);
                    load_kind     = psched_pkg::KIND_RELEASE;
                    load_status   = psched_pkg::ST_OK;
                    load_last     = 1'b0;
                    pend_idx_next = cur_idx;
                    adv           = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    load_task       = 5'(pend_idx_reg);
                    load_kind       = psched_pkg::KIND_RELEASE;
                    load_status     = psched_pkg::ST_OK;
                    pend_valid_next = 1'b0;
                    state_next      = S_ADV;
                end
            end
            S_ADV:
            begin
                sum_next   = rt_reg + {16'd0, step};
                div_dvd    = sum_next;
                div_dsr    = {16'd0, step};
                div_start  = 1'b1;
                state_next = S_ADVW;
            end
            S_ADVW:
            begin
                if (div_done)
                begin
                    rt_next    = (div_rem == 32'd0) ? sum_reg : 32'd0;
                    state_next = S_IDLE;
                end
            end
            S_ANS:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // step to the next slot, rolling into the next level
        if (adv)
        begin
            state_next = S_WALK;
            if (at_end)
            begin
                lv_next = lv_reg + 1'b1;
                sl_next = '0;
            end
            else
                sl_next = sl_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lv_reg         <= '0;
            sl_reg         <= '0;
            rt_reg         <= '0;
            pend_valid_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
            for (int i = 0; i < psched_pkg::LEVELS; i++)
                fill_reg[i] <= '0;
            for (int i = 0; i < psched_pkg::TOTAL; i++)
                mode_reg[i] <= psched_pkg::MODE_WAIT;
        end
        else
        begin
            state_reg      <= state_next;
            lv_reg         <= lv_next;
            sl_reg         <= sl_next;
            rt_reg         <= rt_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            if (fill_we)
                fill_reg[fill_widx] <= fill_reg[fill_widx] + 1'b1;
            if (mode_we)
                mode_reg[mode_widx] <= mode_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        pend_idx_reg   <= pend_idx_next;
        ans_task_reg   <= ans_task_next;
        ans_status_reg <= ans_status_next;
        if (out_load)
        begin
            otask_reg   <= load_task;
            okind_reg   <= load_kind;
            ostatus_reg <= load_status;
            olast_reg   <= load_last;
        end
    end

    // task table: one write port per array, registered read at the walk index
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            per_mem[tab_widx] <= q_item.period;
            off_mem[tab_widx] <= q_item.first_delay;
        end
        per_rd <= per_mem[cur_idx];
        off_rd <= off_mem[cur_idx];
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
            hold_mem[hold_widx] <= hold_wdata;
        hold_rd <= hold_mem[cur_idx];
    end

    assign out_valid = ovalid_reg;
    assign out_task  = otask_reg;
    assign kind      = okind_reg;
    assign status    = ostatus_reg;
    assign last      = olast_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten while held");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("command taken while engine busy");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg != S_IDLE && state_reg != S_ANS))
        else $error("held release outside a tick walk");

endmodule
`default_nettype wire

### rtl/periodic_task_release_scheduler_core.sv
`default_nettype none
// Periodic task release scheduler.
// Commands enter on the s_ stream (tick, create, delay, suspend, resume);
// results leave on the m_ stream, one transaction each, tlast on the final
// result of a command. tuser is 0 for a release, 1 for a command answer.
// Create, delay, suspend and resume each answer once.
// A tick walks the created tasks in priority then slot order; each waiting
// task whose first release time has been reached and whose period is
// nonzero runs a remainder step in the shared divider. The divider and the
// task table read port set the length of a tick. A tick with no release
// gives no transaction; unknown command codes are dropped.
// A two-deep command queue decouples the input from the execution engine.
// The m_ side is held in an output register: when the receiver stalls,
// the engine stalls on its next result and the queue fills, then s_tready
// drops. tick_step is written over APB at address 0, by the user only while
// idle (the block does not enforce this). Reset empties the table (all levels
// unfilled), clears run time, sets tick_step to 1. No clearing pass is needed.
module periodic_task_release_scheduler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[2:0], task_id[7:3], priority_req[9:8], period[41:10],
    // first_delay[73:42], delay_ticks[89:74], zero fill [95:90]
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_task[4:0], status[6:5], zero fill [7]
    output logic [7:0]       m_tdata,
    // kind[0]
    output logic             m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0]       tick_step_reg;
    logic [15:0]       step;
    logic              q_valid;
    logic              q_pop;
    psched_pkg::item_t q_item;
    logic [4:0]        out_task;
    logic [1:0]        status;

    // config write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_step_reg <= 16'd1;
        else if (psel && penable && pwrite && pready
                 && paddr == psched_pkg::ADDR_TICK_STEP)
            tick_step_reg <= pwdata[15:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == psched_pkg::ADDR_TICK_STEP) ? {16'd0, tick_step_reg} : 32'd0;
    // a zero step acts as one
    assign step   = (tick_step_reg == 16'd0) ? 16'd1 : tick_step_reg;

    psched_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .command      (s_tdata[2:0]),
        .task_id      (s_tdata[7:3]),
        .priority_req (s_tdata[9:8]),
        .period       (s_tdata[41:10]),
        .first_delay  (s_tdata[73:42]),
        .delay_ticks  (s_tdata[89:74]),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item)
    );

    psched_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .step      (step),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_task  (out_task),
        .kind      (m_tuser),
        .status    (status),
        .last      (m_tlast)
    );

    assign m_tdata = {1'b0, status, out_task};

endmodule
`default_nettype wire

### bench/periodic_task_release_scheduler_core_test.sv
`timescale 1ns / 100ps
module periodic_task_release_scheduler_core_test;

    typedef struct packed {
        logic [4:0] out_task;
        logic       kind;
        logic [1:0] status;
        logic       last;
    } release_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    periodic_task_release_scheduler_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the task table
    logic [1:0]  sh_mode [psched_pkg::TOTAL];
    logic [31:0] sh_period [psched_pkg::TOTAL];
    logic [31:0] sh_offset [psched_pkg::TOTAL];
    logic [15:0] sh_hold [psched_pkg::TOTAL];
    int          sh_fill [psched_pkg::LEVELS];
    logic [31:0] sh_time;
    logic [15:0] sh_step;

    release_t pending_results[$];
    int  errors;
    int  n_items;
    int  n_results;
    int  n_ticks_released;
    bit  hold_off_rx;
    bit  rx_random;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Limit: the worst run is well under this
    initial
    begin
        #400ms;
        $display("[periodic_task_release_scheduler_core] ERROR");
        $finish;
    end

    function automatic bit is_due(logic [31:0] t, logic [31:0] off, logic [31:0] per);
        if (t < off)
            return 1'b0;
        if (per == 0)
            return t == off;
        return ((t - off) % per) == 0;
    endfunction

    // Advance the shadow table by one command and queue what it produces
    task automatic predict_command(logic [2:0] cmd, logic [4:0] tid, logic [1:0] prio,
                                   logic [31:0] per, logic [31:0] off,
                                   logic [15:0] dly);
        release_t r;
        int n;
        int x;
        int lv;
        int sl;
        bit rel;
        logic [31:0] step;
        n = 0;
        case (cmd)
            psched_pkg::CMD_TICK:
            begin
                step = (sh_step == 0) ? 32'd1 : {16'd0, sh_step};
                for (lv = 0; lv < psched_pkg::LEVELS; lv++)
                    for (sl = 0; sl < sh_fill[lv]; sl++)
                    begin
                        x = lv * psched_pkg::SLOTS + sl;
                        rel = 1'b0;
                        if (sh_mode[x] == psched_pkg::MODE_DELAYED)
                        begin
                            sh_hold[x] = sh_hold[x] - 16'd1;
                            if (sh_hold[x] == 0)
                            begin
                                sh_mode[x] = psched_pkg::MODE_WAIT;
                                rel = 1'b1;
                            end
                        end
                        else if (sh_mode[x] == psched_pkg::MODE_WAIT)
                            rel = is_due(sh_time, sh_offset[x], sh_period[x]);
                        if (rel && n < 32)
                        begin
                            r = '{out_task: x[4:0], kind: psched_pkg::KIND_RELEASE,
                                  status: psched_pkg::ST_OK, last: 1'b0};
                            pending_results.push_back(r);
                            n++;
                        end
                    end
                if (n > 0)
                begin
                    r = pending_results.pop_back();
                    r.last = 1'b1;
                    pending_results.push_back(r);
                    n_ticks_released++;
                end
                sh_time = sh_time + step;
                if (sh_time % step != 0)
                    sh_time = 0;
            end
            psched_pkg::CMD_CREATE:
            begin
                if (sh_fill[prio] >= psched_pkg::SLOTS)
                    r = '{out_task: 5'd0, kind: psched_pkg::KIND_ANSWER,
                          status: psched_pkg::ST_FULL, last: 1'b1};
                else
                begin
                    x = prio * psched_pkg::SLOTS + sh_fill[prio];
                    sh_mode[x] = psched_pkg::MODE_WAIT;
                    sh_period[x] = per;
                    sh_offset[x] = off;
                    sh_hold[x] = 0;
                    sh_fill[prio]++;
                    r = '{out_task: x[4:0], kind: psched_pkg::KIND_ANSWER,
                          status: psched_pkg::ST_OK, last: 1'b1};
                end
                pending_results.push_back(r);
            end
            psched_pkg::CMD_DELAY, psched_pkg::CMD_SUSPEND, psched_pkg::CMD_RESUME:
            begin
                lv = tid / psched_pkg::SLOTS;
                sl = tid % psched_pkg::SLOTS;
                if (lv >= psched_pkg::LEVELS || sl >= sh_fill[lv])
                    r = '{out_task: tid, kind: psched_pkg::KIND_ANSWER,
                          status: psched_pkg::ST_NOTASK, last: 1'b1};
                else
                begin
                    if (cmd == psched_pkg::CMD_DELAY)
                    begin
                        sh_mode[tid] = psched_pkg::MODE_DELAYED;
                        sh_hold[tid] = (dly == 0) ? 16'd1 : dly;
                    end
                    else if (cmd == psched_pkg::CMD_SUSPEND)
                        sh_mode[tid] = psched_pkg::MODE_SUSP;
                    else
                        sh_mode[tid] = psched_pkg::MODE_WAIT;
                    r = '{out_task: tid, kind: psched_pkg::KIND_ANSWER,
                          status: psched_pkg::ST_OK, last: 1'b1};
                end
                pending_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // Drop tvalid for a random number of cycles, or keep offering at once
    task automatic random_gap(int heavy);
        int g;
        g = 0;
        if ($urandom_range(99) < heavy)
            g = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 3);
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // Offer one command, hold it until accepted, then predict
    task automatic send_command(logic [2:0] cmd, logic [4:0] tid, logic [1:0] prio,
                                logic [31:0] per, logic [31:0] off, logic [15:0] dly,
                                int gap_pct = 30);
        random_gap(gap_pct);
        s_tdata <= {6'd0, dly, off, per, prio, tid, cmd};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_command(cmd, tid, prio, per, off, dly);
        n_items++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        // ticks with no release can still be queued and walking the table
        repeat (4000) @(negedge clk);
    endtask

    task automatic write_step(logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= psched_pkg::ADDR_TICK_STEP;
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sh_step = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int g;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_rx)
            begin
                m_tready <= 1'b0;
                repeat (600) @(negedge clk);
                hold_off_rx = 1'b0;
            end
            if (rx_random && $urandom_range(99) < 25)
            begin
                m_tready <= 1'b0;
                g = ($urandom_range(9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 3);
                repeat (g - 1) @(negedge clk);
                @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        release_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: task %0d", m_tdata[4:0]);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tdata[4:0] !== e.out_task)
                begin
                    $error("out_task expected %0d actual %0d", e.out_task, m_tdata[4:0]);
                    errors++;
                end
                if (m_tuser !== e.kind)
                begin
                    $error("kind expected %0d actual %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[6:5] !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_tdata[6:5]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        // empty table: tick gives nothing; commands on unknown ids are rejected, unknown codes are dropped
        send_command(psched_pkg::CMD_TICK, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_DELAY, 5'd31, 2'd0, 32'd0, 32'd0, 16'hFFFF);
        send_command(psched_pkg::CMD_SUSPEND, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_RESUME, 5'd9, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(3'd5, 5'd3, 2'd1, 32'd1, 32'd1, 16'd1);
        send_command(3'd7, 5'd31, 2'd3, '1, '1, '1);
        // period zero releases once, extremes of period and first delay
        send_command(psched_pkg::CMD_CREATE, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_CREATE, 5'd0, 2'd0, 32'd1, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_CREATE, 5'd0, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     16'd0);
        send_command(psched_pkg::CMD_CREATE, 5'd0, 2'd1, 32'd3, 32'd2, 16'd0);
        send_command(psched_pkg::CMD_TICK, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_TICK, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        // zero delay acts as one, suspend cancels a delay, resume
        send_command(psched_pkg::CMD_DELAY, 5'd1, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_DELAY, 5'd8, 2'd0, 32'd0, 32'd0, 16'd3);
        send_command(psched_pkg::CMD_SUSPEND, 5'd8, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_TICK, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_RESUME, 5'd8, 2'd0, 32'd0, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_TICK, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        // fill level 2, then one more is rejected as full
        repeat (psched_pkg::SLOTS)
            send_command(psched_pkg::CMD_CREATE, 5'd0, 2'd2, 32'd1, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_CREATE, 5'd0, 2'd2, 32'd1, 32'd0, 16'd0);
        send_command(psched_pkg::CMD_TICK, 5'd0, 2'd0, 32'd0, 32'd0, 16'd0);
        wait_drained();
    endtask

    task automatic random_command(int gap_pct);
        int r;
        logic [31:0] per;
        logic [31:0] off;
        r = $urandom_range(99);
        per = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 12);
        off = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 30);
        if (r < 45)
            send_command(psched_pkg::CMD_TICK, 5'($urandom()), 2'($urandom()), $urandom(),
                         $urandom(), 16'($urandom()), gap_pct);
        else if (r < 60)
            send_command(psched_pkg::CMD_CREATE, 5'($urandom()), 2'($urandom()), per, off,
                         16'($urandom()), gap_pct);
        else if (r < 72)
            send_command(psched_pkg::CMD_DELAY, 5'($urandom()), 2'd0, 32'd0, 32'd0,
                         ($urandom_range(4) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 6)),
                         gap_pct);
        else if (r < 84)
            send_command(psched_pkg::CMD_SUSPEND, 5'($urandom()), 2'($urandom()), $urandom(),
                         $urandom(), 16'($urandom()), gap_pct);
        else if (r < 96)
            send_command(psched_pkg::CMD_RESUME, 5'($urandom()), 2'($urandom()), $urandom(),
                         $urandom(), 16'($urandom()), gap_pct);
        else
            send_command(3'($urandom_range(5, 7)), 5'($urandom()), 2'($urandom()),
                         $urandom(), $urandom(), 16'($urandom()), gap_pct);
    endtask

    task automatic test_random_steps();
        logic [15:0] steps [4];
        int p;
        steps = '{16'd1, 16'd3, 16'hFFFF, 16'd0};
        for (p = 0; p < 4; p++)
        begin
            write_step(steps[p]);
            repeat (100)
                random_command(30);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while commands keep coming, queue must fill
        write_step(16'd2);
        rx_random = 1'b0;
        hold_off_rx = 1'b1;
        repeat (40)
            random_command(0);
        // sender pauses until every result has come
        wait_drained();
        rx_random = 1'b1;
        repeat (40)
            random_command(50);
        wait_drained();
    endtask

    initial
    begin
        int lv;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_ticks_released = 0;
        hold_off_rx = 1'b0;
        rx_random = 1'b1;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (lv = 0; lv < psched_pkg::TOTAL; lv++)
        begin
            sh_mode[lv] = psched_pkg::MODE_WAIT;
            sh_hold[lv] = 0;
            sh_period[lv] = 0;
            sh_offset[lv] = 0;
        end
        for (lv = 0; lv < psched_pkg::LEVELS; lv++)
            sh_fill[lv] = 0;
        sh_time = 0;
        sh_step = 16'd1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        test_random_steps();
        test_backpressure();

        $display("Covered %0d commands and %0d results, %0d ticks with releases,",
                 n_items, n_results, n_ticks_released);
        $display("tick steps 0, 1, 2, 3 and 65535, full levels and a stalled receiver.");
        if (errors == 0 && pending_results.size() == 0)
            $display("[periodic_task_release_scheduler_core] OK");
        else
            $display("[periodic_task_release_scheduler_core] ERROR");
        $finish;
    end
endmodule
